// File: rtl/core/strs_pkg.sv
package strs_pkg;

	// Fixed field widths
	localparam int VTX_W      = 20;
	localparam int PT_W       = 16;
	localparam int RAD_W      = 15;
	localparam int ID_W       = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INCL_DEL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_P0_X     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_P0_Y     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_P1_X     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_P1_Y     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd6;

	// Region test modes
	localparam logic MODE_RECT   = 1'b0;
	localparam logic MODE_CIRCLE = 1'b1;

endpackage

// File: rtl/core/screen_triangle_region_select_core.sv
// Throughput: one triangle per cycle; a stage holds only when every stage after it is full.
// Triangles that are skipped or miss the region travel the pipe and are dropped at the end.
// Reset (arst_n low, asynchronous) clears the control and valid registers and empties the pipeline;
// the region registers come out of reset as rectangle mode at the origin.
module screen_triangle_region_select_core #(
	parameter int COORD_FRAC_BITS = 4,
	parameter int ID_BITS         = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [strs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [strs_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [strs_pkg::ID_W-1:0]             triangle_id,
	input  logic                                  active,
	input  logic                                  vertices_ok,
	input  logic signed [strs_pkg::VTX_W-1:0]     vertex_a_x,
	input  logic signed [strs_pkg::VTX_W-1:0]     vertex_a_y,
	input  logic signed [strs_pkg::VTX_W-1:0]     vertex_b_x,
	input  logic signed [strs_pkg::VTX_W-1:0]     vertex_b_y,
	input  logic signed [strs_pkg::VTX_W-1:0]     vertex_c_x,
	input  logic signed [strs_pkg::VTX_W-1:0]     vertex_c_y,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [strs_pkg::ID_W-1:0]             selected_id
);

	localparam int F   = COORD_FRAC_BITS;
	localparam int RW  = strs_pkg::PT_W + F;          // scaled region coordinate
	localparam int VW  = strs_pkg::VTX_W;
	localparam int CW  = (RW > VW) ? RW : VW;         // common coordinate width
	localparam int DW  = CW + 1;                      // coordinate difference
	localparam int PW  = 2 * DW;                      // product of two differences
	localparam int OW  = PW + 1;                      // sum or difference of products
	localparam int H   = DW;                          // half of a PW-bit operand
	localparam int R2W = 2 * strs_pkg::RAD_W;         // radius squared, whole pixels
	localparam int NW  = PW + R2W + 2 * F;            // vertex distance compare
	localparam int SQW = 4 * H;                       // cross product squared
	localparam int RDW = R2W + 2 * H;                 // radius squared times squared edge length
	localparam int XW  = SQW + R2W + 2 * F;           // edge distance compare

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic                               mode_q;
	logic                               incl_q;
	logic signed [strs_pkg::PT_W-1:0]   p0x_q, p0y_q, p1x_q, p1y_q;
	logic [strs_pkg::RAD_W-1:0]         rad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= strs_pkg::MODE_RECT;
			incl_q <= 1'b0;
			p0x_q  <= '0;
			p0y_q  <= '0;
			p1x_q  <= '0;
			p1y_q  <= '0;
			rad_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				strs_pkg::REG_MODE:     mode_q <= cfg_data[0];
				strs_pkg::REG_INCL_DEL: incl_q <= cfg_data[0];
				strs_pkg::REG_P0_X:     p0x_q  <= cfg_data;
				strs_pkg::REG_P0_Y:     p0y_q  <= cfg_data;
				strs_pkg::REG_P1_X:     p1x_q  <= cfg_data;
				strs_pkg::REG_P1_Y:     p1y_q  <= cfg_data;
				strs_pkg::REG_RADIUS:   rad_q  <= cfg_data[strs_pkg::RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stall control: a stage advances when it is empty or the next one advances.
	// The last stage drains at once when its triangle is not selected.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic hit_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7      = !v_s7 || !hit_s7 || out_ready;
	assign en6      = !v_s6 || en7;
	assign en5      = !v_s5 || en6;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: capture the triangle, order the corners, scale the region
	// ------------------------------------------------------------------
	logic signed [strs_pkg::PT_W-1:0] lo_x, hi_x, lo_y, hi_y;
	logic signed [CW-1:0]             vx_c [3];
	logic signed [CW-1:0]             vy_c [3];

	assign lo_x = (p0x_q < p1x_q) ? p0x_q : p1x_q;
	assign hi_x = (p0x_q < p1x_q) ? p1x_q : p0x_q;
	assign lo_y = (p0y_q < p1y_q) ? p0y_q : p1y_q;
	assign hi_y = (p0y_q < p1y_q) ? p1y_q : p0y_q;

	assign vx_c[0] = CW'(vertex_a_x);
	assign vy_c[0] = CW'(vertex_a_y);
	assign vx_c[1] = CW'(vertex_b_x);
	assign vy_c[1] = CW'(vertex_b_y);
	assign vx_c[2] = CW'(vertex_c_x);
	assign vy_c[2] = CW'(vertex_c_y);

	logic                 take_s1, mode_s1;
	logic [ID_BITS-1:0]   id_s1;
	logic signed [CW-1:0] vx_s1 [3];
	logic signed [CW-1:0] vy_s1 [3];
	logic signed [CW-1:0] bl_s1, br_s1, bt_s1, bb_s1, cx_s1, cy_s1;
	logic [R2W-1:0]       rsq_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			take_s1 <= vertices_ok && (active || incl_q);
			mode_s1 <= mode_q;
			id_s1   <= triangle_id[ID_BITS-1:0];
			vx_s1   <= vx_c;
			vy_s1   <= vy_c;
			bl_s1   <= CW'(lo_x) <<< F;
			br_s1   <= CW'(hi_x) <<< F;
			bt_s1   <= CW'(lo_y) <<< F;
			bb_s1   <= CW'(hi_y) <<< F;
			cx_s1   <= CW'(p0x_q) <<< F;
			cy_s1   <= CW'(p0y_q) <<< F;
			rsq_s1  <= R2W'(rad_q) * R2W'(rad_q);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: differences and all first-level products.
	// Rectangle: triangle edge i against corner j, orient = pa - pb.
	// Circle: vertex distances, edge length, projection and cross terms.
	// ------------------------------------------------------------------
	logic signed [CW-1:0] qx_c [4];
	logic signed [CW-1:0] qy_c [4];
	logic signed [DW-1:0] ex_c [3];
	logic signed [DW-1:0] ey_c [3];
	logic signed [DW-1:0] wx_c [3];
	logic signed [DW-1:0] wy_c [3];
	logic signed [DW-1:0] dx_c [3];
	logic signed [DW-1:0] dy_c [3];
	logic signed [DW-1:0] qdx_c [3][4];
	logic signed [DW-1:0] qdy_c [3][4];
	logic signed [PW-1:0] pa_c [3][4];
	logic signed [PW-1:0] pb_c [3][4];
	logic signed [PW-1:0] dxx_c [3], dyy_c [3];
	logic signed [PW-1:0] exx_c [3], eyy_c [3];
	logic signed [PW-1:0] wex_c [3], wey_c [3];
	logic signed [PW-1:0] cra_c [3], crb_c [3];

	assign qx_c[0] = bl_s1;
	assign qy_c[0] = bt_s1;
	assign qx_c[1] = br_s1;
	assign qy_c[1] = bt_s1;
	assign qx_c[2] = br_s1;
	assign qy_c[2] = bb_s1;
	assign qx_c[3] = bl_s1;
	assign qy_c[3] = bb_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ex_c[i]  = DW'(vx_s1[(i + 1) % 3]) - DW'(vx_s1[i]);
			ey_c[i]  = DW'(vy_s1[(i + 1) % 3]) - DW'(vy_s1[i]);
			wx_c[i]  = DW'(cx_s1) - DW'(vx_s1[i]);
			wy_c[i]  = DW'(cy_s1) - DW'(vy_s1[i]);
			dx_c[i]  = DW'(vx_s1[i]) - DW'(cx_s1);
			dy_c[i]  = DW'(vy_s1[i]) - DW'(cy_s1);
			dxx_c[i] = dx_c[i] * dx_c[i];
			dyy_c[i] = dy_c[i] * dy_c[i];
			exx_c[i] = ex_c[i] * ex_c[i];
			eyy_c[i] = ey_c[i] * ey_c[i];
			wex_c[i] = wx_c[i] * ex_c[i];
			wey_c[i] = wy_c[i] * ey_c[i];
			cra_c[i] = wx_c[i] * ey_c[i];
			crb_c[i] = wy_c[i] * ex_c[i];
			for (int j = 0; j < 4; j++) begin
				qdx_c[i][j] = DW'(qx_c[j]) - DW'(vx_s1[i]);
				qdy_c[i][j] = DW'(qy_c[j]) - DW'(vy_s1[i]);
				pa_c[i][j]  = ex_c[i] * qdy_c[i][j];
				pb_c[i][j]  = ey_c[i] * qdx_c[i][j];
			end
		end
	end

	logic                 take_s2, mode_s2;
	logic [ID_BITS-1:0]   id_s2;
	logic signed [CW-1:0] vx_s2 [3];
	logic signed [CW-1:0] vy_s2 [3];
	logic signed [CW-1:0] bl_s2, br_s2, bt_s2, bb_s2;
	logic [R2W-1:0]       rsq_s2;
	logic signed [PW-1:0] pa_s2 [3][4];
	logic signed [PW-1:0] pb_s2 [3][4];
	logic signed [PW-1:0] dxx_s2 [3], dyy_s2 [3];
	logic signed [PW-1:0] exx_s2 [3], eyy_s2 [3];
	logic signed [PW-1:0] wex_s2 [3], wey_s2 [3];
	logic signed [PW-1:0] cra_s2 [3], crb_s2 [3];

	always_ff @(posedge clk) begin
		if (en2) begin
			take_s2 <= take_s1;
			mode_s2 <= mode_s1;
			id_s2   <= id_s1;
			vx_s2   <= vx_s1;
			vy_s2   <= vy_s1;
			bl_s2   <= bl_s1;
			br_s2   <= br_s1;
			bt_s2   <= bt_s1;
			bb_s2   <= bb_s1;
			rsq_s2  <= rsq_s1;
			pa_s2   <= pa_c;
			pb_s2   <= pb_c;
			dxx_s2  <= dxx_c;
			dyy_s2  <= dyy_c;
			exx_s2  <= exx_c;
			eyy_s2  <= eyy_c;
			wex_s2  <= wex_c;
			wey_s2  <= wey_c;
			cra_s2  <= cra_c;
			crb_s2  <= crb_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: orientations and sums; compare-only rectangle terms.
	// The rectangle edges are axis aligned, so their orientation against a
	// vertex reduces to a sign test on one coordinate.
	// ------------------------------------------------------------------
	logic signed [CW-1:0] qx2_c [4];
	logic signed [CW-1:0] qy2_c [4];
	logic signed [OW-1:0] o_c [3][4];
	logic signed [OW-1:0] sd2_c [3], sden_c [3], dot_c [3], cr_c [3];
	logic [PW-1:0]        d2_c [3], den_c [3];
	logic                 rpos_c [4][3];
	logic                 rneg_c [4][3];
	logic                 rbox_c [4][3];
	logic                 ebox_c [3][4];
	logic                 vin_c;
	logic                 w_pos, h_pos;

	assign qx2_c[0] = bl_s2;
	assign qy2_c[0] = bt_s2;
	assign qx2_c[1] = br_s2;
	assign qy2_c[1] = bt_s2;
	assign qx2_c[2] = br_s2;
	assign qy2_c[2] = bb_s2;
	assign qx2_c[3] = bl_s2;
	assign qy2_c[3] = bb_s2;
	assign w_pos    = br_s2 > bl_s2;
	assign h_pos    = bb_s2 > bt_s2;

	always_comb begin
		vin_c = 1'b0;
		for (int k = 0; k < 3; k++) begin
			sd2_c[k]  = OW'(dxx_s2[k]) + OW'(dyy_s2[k]);
			d2_c[k]   = sd2_c[k][PW-1:0];
			sden_c[k] = OW'(exx_s2[k]) + OW'(eyy_s2[k]);
			den_c[k]  = sden_c[k][PW-1:0];
			dot_c[k]  = OW'(wex_s2[k]) + OW'(wey_s2[k]);
			cr_c[k]   = OW'(cra_s2[k]) - OW'(crb_s2[k]);
			for (int j = 0; j < 4; j++) begin
				o_c[k][j]    = OW'(pa_s2[k][j]) - OW'(pb_s2[k][j]);
				ebox_c[k][j] =
					((qx2_c[j] >= vx_s2[k]) || (qx2_c[j] >= vx_s2[(k + 1) % 3])) &&
					((qx2_c[j] <= vx_s2[k]) || (qx2_c[j] <= vx_s2[(k + 1) % 3])) &&
					((qy2_c[j] >= vy_s2[k]) || (qy2_c[j] >= vy_s2[(k + 1) % 3])) &&
					((qy2_c[j] <= vy_s2[k]) || (qy2_c[j] <= vy_s2[(k + 1) % 3]));
			end
			if (vx_s2[k] >= bl_s2 && vx_s2[k] <= br_s2 &&
			    vy_s2[k] >= bt_s2 && vy_s2[k] <= bb_s2) begin
				vin_c = 1'b1;
			end
			// top edge, left to right
			rpos_c[0][k] = w_pos && vy_s2[k] > bt_s2;
			rneg_c[0][k] = w_pos && vy_s2[k] < bt_s2;
			rbox_c[0][k] = vx_s2[k] >= bl_s2 && vx_s2[k] <= br_s2 && vy_s2[k] == bt_s2;
			// right edge, top to bottom
			rpos_c[1][k] = h_pos && vx_s2[k] < br_s2;
			rneg_c[1][k] = h_pos && vx_s2[k] > br_s2;
			rbox_c[1][k] = vy_s2[k] >= bt_s2 && vy_s2[k] <= bb_s2 && vx_s2[k] == br_s2;
			// bottom edge, right to left
			rpos_c[2][k] = w_pos && vy_s2[k] < bb_s2;
			rneg_c[2][k] = w_pos && vy_s2[k] > bb_s2;
			rbox_c[2][k] = vx_s2[k] >= bl_s2 && vx_s2[k] <= br_s2 && vy_s2[k] == bb_s2;
			// left edge, bottom to top
			rpos_c[3][k] = h_pos && vx_s2[k] > bl_s2;
			rneg_c[3][k] = h_pos && vx_s2[k] < bl_s2;
			rbox_c[3][k] = vy_s2[k] >= bt_s2 && vy_s2[k] <= bb_s2 && vx_s2[k] == bl_s2;
		end
	end

	logic                 take_s3, mode_s3;
	logic [ID_BITS-1:0]   id_s3;
	logic [R2W-1:0]       rsq_s3;
	logic signed [OW-1:0] o_s3 [3][4];
	logic signed [OW-1:0] dot_s3 [3], cr_s3 [3];
	logic [PW-1:0]        d2_s3 [3], den_s3 [3];
	logic                 rpos_s3 [4][3];
	logic                 rneg_s3 [4][3];
	logic                 rbox_s3 [4][3];
	logic                 ebox_s3 [3][4];
	logic                 vin_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			take_s3 <= take_s2;
			mode_s3 <= mode_s2;
			id_s3   <= id_s2;
			rsq_s3  <= rsq_s2;
			o_s3    <= o_c;
			dot_s3  <= dot_c;
			cr_s3   <= cr_c;
			d2_s3   <= d2_c;
			den_s3  <= den_c;
			rpos_s3 <= rpos_c;
			rneg_s3 <= rneg_c;
			rbox_s3 <= rbox_c;
			ebox_s3 <= ebox_c;
			vin_s3  <= vin_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: rectangle verdict; circle verdict for everything but the
	// interior of an edge, which needs the wide products downstream.
	// ------------------------------------------------------------------
	logic          rhit_c, chit_c;
	logic          inner_c [3];
	logic [PW-1:0] ac_c [3];
	logic signed [OW-1:0] acw_c [3];
	logic          cneg, cpos;
	logic [NW-1:0] r2n;

	assign r2n = NW'(rsq_s3) << (2 * F);

	always_comb begin
		rhit_c = vin_s3;
		chit_c = 1'b0;
		for (int j = 0; j < 4; j++) begin
			// corner inside triangle: edge orientations all one sign, not all zero
			if ((o_s3[0][j] < 0 || o_s3[1][j] < 0 || o_s3[2][j] < 0) !=
			    (o_s3[0][j] > 0 || o_s3[1][j] > 0 || o_s3[2][j] > 0)) begin
				rhit_c = 1'b1;
			end
			for (int i = 0; i < 3; i++) begin
				if (((o_s3[i][j] > 0 && o_s3[i][(j + 1) % 4] < 0) ||
				     (o_s3[i][j] < 0 && o_s3[i][(j + 1) % 4] > 0)) &&
				    ((rpos_s3[j][i] && rneg_s3[j][(i + 1) % 3]) ||
				     (rneg_s3[j][i] && rpos_s3[j][(i + 1) % 3]))) begin
					rhit_c = 1'b1;
				end
				if (o_s3[i][j] == 0 && ebox_s3[i][j]) rhit_c = 1'b1;
				if (o_s3[i][(j + 1) % 4] == 0 && ebox_s3[i][(j + 1) % 4]) rhit_c = 1'b1;
				if (!rpos_s3[j][i] && !rneg_s3[j][i] && rbox_s3[j][i]) rhit_c = 1'b1;
				if (!rpos_s3[j][(i + 1) % 3] && !rneg_s3[j][(i + 1) % 3] &&
				    rbox_s3[j][(i + 1) % 3]) begin
					rhit_c = 1'b1;
				end
			end
		end

		// center inside triangle: the cross terms are the edge orientations negated
		cneg = cr_s3[0] < 0 || cr_s3[1] < 0 || cr_s3[2] < 0;
		cpos = cr_s3[0] > 0 || cr_s3[1] > 0 || cr_s3[2] > 0;
		if (cneg != cpos) chit_c = 1'b1;

		for (int i = 0; i < 3; i++) begin
			if (NW'(d2_s3[i]) <= r2n) chit_c = 1'b1;
			acw_c[i] = cr_s3[i][OW-1] ? -cr_s3[i] : cr_s3[i];
			ac_c[i]  = acw_c[i][PW-1:0];
			if (den_s3[i] == '0 || dot_s3[i][OW-1] || dot_s3[i] == '0) begin
				inner_c[i] = 1'b0;
				if (NW'(d2_s3[i]) <= r2n) chit_c = 1'b1;
			end else if (dot_s3[i] >= $signed({1'b0, den_s3[i]})) begin
				inner_c[i] = 1'b0;
				if (NW'(d2_s3[(i + 1) % 3]) <= r2n) chit_c = 1'b1;
			end else begin
				inner_c[i] = 1'b1;
			end
		end
	end

	logic               take_s4, mode_s4, rhit_s4, chit_s4;
	logic [ID_BITS-1:0] id_s4;
	logic [R2W-1:0]     rsq_s4;
	logic               inner_s4 [3];
	logic [PW-1:0]      ac_s4 [3], den_s4 [3];

	always_ff @(posedge clk) begin
		if (en4) begin
			take_s4  <= take_s3;
			mode_s4  <= mode_s3;
			rhit_s4  <= rhit_c;
			chit_s4  <= chit_c;
			id_s4    <= id_s3;
			rsq_s4   <= rsq_s3;
			inner_s4 <= inner_c;
			ac_s4    <= ac_c;
			den_s4   <= den_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: partial products of cross^2 and r^2 * len^2, split in halves
	// ------------------------------------------------------------------
	logic               take_s5, mode_s5, rhit_s5, chit_s5;
	logic [ID_BITS-1:0] id_s5;
	logic               inner_s5 [3];
	logic [2*H-1:0]     ahh_s5 [3], ahl_s5 [3], all_s5 [3];
	logic [R2W+H-1:0]   rdh_s5 [3], rdl_s5 [3];

	always_ff @(posedge clk) begin
		if (en5) begin
			take_s5  <= take_s4;
			mode_s5  <= mode_s4;
			rhit_s5  <= rhit_s4;
			chit_s5  <= chit_s4;
			id_s5    <= id_s4;
			inner_s5 <= inner_s4;
			for (int i = 0; i < 3; i++) begin
				ahh_s5[i] <= ac_s4[i][PW-1:H] * ac_s4[i][PW-1:H];
				ahl_s5[i] <= ac_s4[i][PW-1:H] * ac_s4[i][H-1:0];
				all_s5[i] <= ac_s4[i][H-1:0] * ac_s4[i][H-1:0];
				rdh_s5[i] <= rsq_s4 * den_s4[i][PW-1:H];
				rdl_s5[i] <= rsq_s4 * den_s4[i][H-1:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: assemble the full products
	// ------------------------------------------------------------------
	logic               take_s6, mode_s6, rhit_s6, chit_s6;
	logic [ID_BITS-1:0] id_s6;
	logic               inner_s6 [3];
	logic [SQW-1:0]     sq_s6 [3];
	logic [RDW-1:0]     rd_s6 [3];

	always_ff @(posedge clk) begin
		if (en6) begin
			take_s6  <= take_s5;
			mode_s6  <= mode_s5;
			rhit_s6  <= rhit_s5;
			chit_s6  <= chit_s5;
			id_s6    <= id_s5;
			inner_s6 <= inner_s5;
			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= (SQW'(ahh_s5[i]) << (2 * H)) + (SQW'(ahl_s5[i]) << (H + 1)) +
				            SQW'(all_s5[i]);
				rd_s6[i] <= (RDW'(rdh_s5[i]) << H) + RDW'(rdl_s5[i]);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: edge interior compare, final verdict, output register
	// ------------------------------------------------------------------
	logic               hit_c;
	logic [ID_BITS-1:0] id_s7;

	always_comb begin
		hit_c = chit_s6;
		for (int i = 0; i < 3; i++) begin
			if (inner_s6[i] && XW'(sq_s6[i]) <= (XW'(rd_s6[i]) << (2 * F))) hit_c = 1'b1;
		end
		if (mode_s6 == strs_pkg::MODE_RECT) hit_c = rhit_s6;
		hit_c = hit_c && take_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s7 <= 1'b0;
		end else if (en7) begin
			hit_s7 <= hit_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en7) id_s7 <= id_s6;
	end

	assign out_valid   = v_s7 && hit_s7;
	assign selected_id = strs_pkg::ID_W'(id_s7);

endmodule

// File: rtl/core/strs_checker.sv
module strs_checker #(
	parameter int ID_BITS = 32
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [strs_pkg::ID_W-1:0]  selected_id
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(selected_id))
		else $error("stalled result dropped or changed");

	// an empty output slot never blocks intake
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with output empty");

	// id bits above the configured width stay clear
	a_id_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (selected_id >> ID_BITS) == '0)
		else $error("selected id exceeds id width");

	// no result is present when reset is released
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result present right after reset");

endmodule

bind screen_triangle_region_select_core strs_checker #(.ID_BITS(ID_BITS)) u_strs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.selected_id (selected_id)
);
